[rtl/core/u8d_pkg.sv]
package u8d_pkg;

    localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;

    // one accepted byte, reduced to the results it causes:
    // count results, all U+FFFD except an optional value at val_pos
    typedef struct packed {
        logic [2:0]  count;
        logic [1:0]  val_pos;
        logic        has_val;
        logic [20:0] val_cp;
        logic        val_bad;
        logic        text_end;
    } u8d_job_t;

    // head of the queue as seen by the back end
    typedef struct packed {
        logic     valid;
        u8d_job_t job;
    } u8d_head_t;

    // number of continuation bytes a lead byte asks for, zero if not a lead
    function automatic logic [1:0] conts_needed(input logic [7:0] lead);
        logic [1:0] need;
        need = 2'd0;
        if (lead[7:5] == 3'b110)
            need = 2'd1;
        else if (lead[7:4] == 4'b1110)
            need = 2'd2;
        else if (lead[7:3] == 5'b11110)
            need = 2'd3;
        return need;
    endfunction

endpackage

[rtl/core/utf8_stream_decoder_unit.sv]
// UTF-8 stream decoder
// input words carry one text byte (data_byte) and an end-of-text mark (text_end);
// a word is taken on a rising edge with in_valid high and in_stall low
// output words carry one code point with was_invalid, run_last and text_last;
// a word is taken on a rising edge with out_valid high and out_stall low
// the front end classifies each byte and tracks the held lead and continuations,
// a two-entry queue of result descriptors decouples it from the back end,
// which, while out_stall is low, plays out one output word per cycle
// from the output register; a byte that completes a code point is queued and
// then loaded into that register; a byte that is only held produces nothing
// throughput: one byte per cycle while out_stall is low and each byte gives at
// most one result; a byte that gives n results (up to four) holds the back end
// until all n are played out; when out_stall is high the output word holds and
// the queue fills, then in_stall rises; held bytes are never lost
// reset clears the held lead, the queue and the output valid flag
module utf8_stream_decoder_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        text_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [20:0] code_point,
    output logic        was_invalid,
    output logic        run_last,
    output logic        text_last
);

    logic               q_full;
    logic               push;
    logic               pop;
    u8d_pkg::u8d_job_t  push_job;
    u8d_pkg::u8d_head_t head;

    u8d_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .text_end  (text_end),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job)
    );

    u8d_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (q_full),
        .head     (head)
    );

    u8d_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .code_point  (code_point),
        .was_invalid (was_invalid),
        .run_last    (run_last),
        .text_last   (text_last)
    );

endmodule

[rtl/core/u8d_front.sv]
module u8d_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          data_byte,
    input  logic                text_end,
    input  logic                q_full,
    output logic                push,
    output u8d_pkg::u8d_job_t   push_job
);

    logic [7:0] held_lead_reg;
    logic [7:0] held_lead_next;
    logic [1:0] held_count_reg;
    logic [1:0] held_count_next;
    logic [5:0] held_conts_reg [2];

    logic       accept;
    logic       held;
    logic       is_cont;
    logic       complete;
    logic       store_en;
    logic [1:0] need_held;
    logic [1:0] need_byte;
    logic [1:0] pre_reps;
    logic [1:0] post_reps;
    logic [7:0] lead_after;
    logic [1:0] count_after;
    logic [20:0] assembled;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        held      = held_lead_reg != 8'd0;
        need_held = u8d_pkg::conts_needed(held_lead_reg);
        need_byte = u8d_pkg::conts_needed(data_byte);
        is_cont   = data_byte[7:6] == 2'b10;
        complete  = ({1'b0, held_count_reg} + 3'd1) >= {1'b0, need_held};

        unique case (need_held)
            2'd1:    assembled = {10'd0, held_lead_reg[4:0], data_byte[5:0]};
            2'd2:    assembled = {5'd0, held_lead_reg[3:0], held_conts_reg[0], data_byte[5:0]};
            2'd3:    assembled = {held_lead_reg[2:0], held_conts_reg[0], held_conts_reg[1],
                                  data_byte[5:0]};
            default: assembled = u8d_pkg::REPLACEMENT_CP;
        endcase

        pre_reps         = 2'd0;
        store_en         = 1'b0;
        lead_after       = held_lead_reg;
        count_after      = held_count_reg;
        push_job.has_val = 1'b0;
        push_job.val_cp  = u8d_pkg::REPLACEMENT_CP;
        push_job.val_bad = 1'b1;

        if (held && is_cont)
        begin
            if (complete)
            begin
                push_job.has_val = 1'b1;
                push_job.val_cp  = assembled;
                push_job.val_bad = 1'b0;
                lead_after       = 8'd0;
                count_after      = 2'd0;
            end
            else
            begin
                store_en    = 1'b1;
                count_after = held_count_reg + 2'd1;
            end
        end
        else
        begin
            // broken sequence: lead and each held continuation are replaced
            if (held)
                pre_reps = held_count_reg + 2'd1;
            lead_after  = 8'd0;
            count_after = 2'd0;
            if (!data_byte[7])
            begin
                push_job.has_val = 1'b1;
                push_job.val_cp  = {13'd0, data_byte};
                push_job.val_bad = 1'b0;
            end
            else if (need_byte != 2'd0)
            begin
                lead_after = data_byte;
            end
            else
            begin
                push_job.has_val = 1'b1;
            end
        end

        // end of text flushes whatever is still held
        post_reps = 2'd0;
        if (text_end && lead_after != 8'd0)
            post_reps = count_after + 2'd1;

        held_lead_next  = text_end ? 8'd0 : lead_after;
        held_count_next = text_end ? 2'd0 : count_after;

        push_job.count    = {1'b0, pre_reps} + {2'd0, push_job.has_val} + {1'b0, post_reps};
        push_job.val_pos  = pre_reps;
        push_job.text_end = text_end;
        push              = accept && (push_job.count != 3'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_lead_reg  <= 8'd0;
            held_count_reg <= 2'd0;
        end
        else if (accept)
        begin
            held_lead_reg  <= held_lead_next;
            held_count_reg <= held_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && store_en)
            held_conts_reg[held_count_reg[0]] <= data_byte[5:0];
    end

endmodule

[rtl/core/u8d_queue.sv]
module u8d_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  u8d_pkg::u8d_job_t   push_job,
    input  logic                pop,
    output logic                full,
    output u8d_pkg::u8d_head_t  head
);

    u8d_pkg::u8d_job_t entries_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_pop;

    assign full       = count_reg == 2'd2;
    assign head.valid = count_reg != 2'd0;
    assign head.job   = entries_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (!push && do_pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_job;
    end

endmodule

[rtl/core/u8d_back.sv]
module u8d_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  u8d_pkg::u8d_head_t  head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [20:0]         code_point,
    output logic                was_invalid,
    output logic                run_last,
    output logic                text_last
);

    logic        out_valid_reg;
    logic [1:0]  idx_reg;
    logic [1:0]  idx_next;
    logic [20:0] code_point_reg;
    logic        was_invalid_reg;
    logic        run_last_reg;
    logic        text_last_reg;

    logic        load;
    logic        last;
    logic        sel_val;

    assign out_valid   = out_valid_reg;
    assign code_point  = code_point_reg;
    assign was_invalid = was_invalid_reg;
    assign run_last    = run_last_reg;
    assign text_last   = text_last_reg;

    // output register refills when empty or being taken
    assign load    = !out_valid_reg || !out_stall;
    assign last    = ({1'b0, idx_reg} + 3'd1) == head.job.count;
    assign sel_val = head.job.has_val && (idx_reg == head.job.val_pos);
    assign pop     = load && head.valid && last;
    assign idx_next = last ? 2'd0 : idx_reg + 2'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else if (load)
        begin
            out_valid_reg <= head.valid;
            if (head.valid)
                idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && head.valid)
        begin
            code_point_reg  <= sel_val ? head.job.val_cp : u8d_pkg::REPLACEMENT_CP;
            was_invalid_reg <= sel_val ? head.job.val_bad : 1'b1;
            run_last_reg    <= last;
            text_last_reg   <= last && head.job.text_end;
        end
    end

endmodule
